### rtl/qsl_pkg.sv
`default_nettype none
// ============================================================================
// qsl_pkg: shared types for the quicksort sorter core
// Controller states and the command and status bundles that join the
// controller to the datapath.
// ============================================================================
package qsl_pkg;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_POP,
        S_POPW,
        S_PIV,
        S_SCAN,
        S_CMP,
        S_SWAP,
        S_FIN1,
        S_FIN2,
        S_PUSHL,
        S_PUSHR,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath, one bit per operation.
    typedef struct packed {
        logic load;          // store the incoming item or flag an overflow
        logic init_push;     // push the full range of the set
        logic pop;           // read the top of the range stack
        logic take_range;    // latch low and high, read the pivot
        logic take_pivot;    // latch the pivot, start the scan at low
        logic rd_pair;       // read the elements at the scan and place indexes
        logic rd_place;      // read the element at the place index
        logic wr_place_a;    // element at place <= element read at scan index
        logic wr_j_b;        // element at scan index <= element read at place
        logic wr_hi_b;       // element at high <= element read at place
        logic wr_place_piv;  // element at place <= pivot
        logic inc_place;
        logic inc_j;
        logic push_l;        // push the range left of the pivot
        logic push_r;        // push the range right of the pivot
        logic emit_rd;       // read the next sorted element and present it
        logic emit_done;     // clear the set state after the final element
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic le;            // scanned element is less than or equal to the pivot
        logic place_eq_j;
        logic j_eq_hi;
        logic sp_zero;
        logic n_lt2;
        logic k_last;
        logic push_l_ok;
        logic push_r_ok;
    } t_stat;

endpackage
`default_nettype wire

### rtl/qsl_ctrl.sv
`default_nettype none
// ============================================================================
// qsl_ctrl: sequencer for the quicksort sorter core
// Walks loading, range stack pops, Lomuto partition scans, pushes and
// emission, issuing one command bundle per cycle.
// ============================================================================
module qsl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_last_in,
    input  wire qsl_pkg::t_stat i_stat,
    output qsl_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import qsl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_in) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (i_stat.n_lt2) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.init_push = 1'b1;
                    n_state         = S_POP;
                end
            end
            S_POP: begin
                if (i_stat.sp_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POPW;
                end
            end
            S_POPW: begin
                o_cmd.take_range = 1'b1;
                n_state          = S_PIV;
            end
            S_PIV: begin
                o_cmd.take_pivot = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.j_eq_hi) begin
                    o_cmd.rd_place = 1'b1;
                    n_state        = S_FIN1;
                end else begin
                    o_cmd.rd_pair = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.le) begin
                    if (i_stat.place_eq_j) begin
                        // Swapping an element with itself changes nothing.
                        o_cmd.inc_place = 1'b1;
                        o_cmd.inc_j     = 1'b1;
                        n_state         = S_SCAN;
                    end else begin
                        o_cmd.wr_place_a = 1'b1;
                        n_state          = S_SWAP;
                    end
                end else begin
                    o_cmd.inc_j = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SWAP: begin
                o_cmd.wr_j_b    = 1'b1;
                o_cmd.inc_place = 1'b1;
                o_cmd.inc_j     = 1'b1;
                n_state         = S_SCAN;
            end
            S_FIN1: begin
                o_cmd.wr_hi_b = 1'b1;
                n_state       = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.wr_place_piv = 1'b1;
                n_state            = S_PUSHL;
            end
            S_PUSHL: begin
                o_cmd.push_l = i_stat.push_l_ok;
                n_state      = S_PUSHR;
            end
            S_PUSHR: begin
                o_cmd.push_r = i_stat.push_r_ok;
                n_state      = S_POP;
            end
            S_EMIT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_stat.k_last) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_busy = (r_state != S_LOAD);

endmodule
`default_nettype wire

### rtl/qsl_dp.sv
`default_nettype none
// ============================================================================
// qsl_dp: datapath of the quicksort sorter core
// Element memory with one write and two registered read ports, the range
// stack memory, scan indexes, pivot register and the result registers.
// ============================================================================
module qsl_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire qsl_pkg::t_cmd  i_cmd,
    output qsl_pkg::t_stat      o_stat,
    input  wire logic [31:0]    i_value,
    output logic [31:0]         o_sorted_value,
    output logic                o_last_out,
    output logic                o_dropped,
    output logic                o_strobe
);
    import qsl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]     r_mem [DEPTH];
    logic [2*AW-1:0] r_stk [DEPTH];

    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic [CW-1:0]   r_sp;
    logic [AW-1:0]   r_k;
    logic [AW-1:0]   r_lo;
    logic [AW-1:0]   r_hi;
    logic [AW-1:0]   r_place;
    logic [AW-1:0]   r_j;
    logic [31:0]     r_pivot;
    logic [31:0]     r_rd_a;
    logic [31:0]     r_rd_b;
    logic [2*AW-1:0] r_stk_rd;
    logic            r_strobe;
    logic            r_last;
    logic            r_dropped;

    logic            w_not_full;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [31:0]     w_wdata;
    logic            w_rd_a_en;
    logic [AW-1:0]   w_raddr_a;
    logic            w_rd_b_en;
    logic            w_swe;
    logic [2*AW-1:0] w_sdata;
    logic [CW-1:0]   w_sp_dec;
    logic [CW-1:0]   w_count_dec;
    logic [AW:0]     w_left_len;
    logic [AW:0]     w_right_len;

    assign w_not_full  = (r_count < CW'(DEPTH));
    assign w_sp_dec    = r_sp - CW'(1);
    assign w_count_dec = r_count - CW'(1);
    assign w_left_len  = {1'b0, r_place} - {1'b0, r_lo};
    assign w_right_len = {1'b0, r_hi} - {1'b0, r_place};

    // Element memory write port.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_place;
        w_wdata = r_rd_a;
        if (i_cmd.load) begin
            w_we    = w_not_full;
            w_waddr = r_count[AW-1:0];
            w_wdata = i_value;
        end else if (i_cmd.wr_place_a) begin
            w_we    = 1'b1;
            w_waddr = r_place;
            w_wdata = r_rd_a;
        end else if (i_cmd.wr_j_b) begin
            w_we    = 1'b1;
            w_waddr = r_j;
            w_wdata = r_rd_b;
        end else if (i_cmd.wr_hi_b) begin
            w_we    = 1'b1;
            w_waddr = r_hi;
            w_wdata = r_rd_b;
        end else if (i_cmd.wr_place_piv) begin
            w_we    = 1'b1;
            w_waddr = r_place;
            w_wdata = r_pivot;
        end
    end

    // Element memory read ports. Port B always reads at the place index.
    always_comb begin
        w_rd_a_en = i_cmd.take_range | i_cmd.rd_pair | i_cmd.emit_rd;
        w_rd_b_en = i_cmd.rd_pair | i_cmd.rd_place;
        if (i_cmd.take_range) begin
            w_raddr_a = r_stk_rd[2*AW-1:AW];
        end else if (i_cmd.emit_rd) begin
            w_raddr_a = r_k;
        end else begin
            w_raddr_a = r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_a_en) begin
            r_rd_a <= r_mem[w_raddr_a];
        end
        if (w_rd_b_en) begin
            r_rd_b <= r_mem[r_place];
        end
    end

    // Range stack: entries hold high in the upper half and low in the lower.
    always_comb begin
        w_swe   = i_cmd.init_push | i_cmd.push_l | i_cmd.push_r;
        w_sdata = {w_count_dec[AW-1:0], AW'(0)};
        if (i_cmd.push_l) begin
            w_sdata = {r_place - AW'(1), r_lo};
        end else if (i_cmd.push_r) begin
            w_sdata = {r_hi, r_place + AW'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_stk[r_sp[AW-1:0]] <= w_sdata;
        end
        if (i_cmd.pop) begin
            r_stk_rd <= r_stk[w_sp_dec[AW-1:0]];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_sp     <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_rd;
            if (i_cmd.load) begin
                if (w_not_full) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.init_push || i_cmd.push_l || i_cmd.push_r) begin
                r_sp <= r_sp + CW'(1);
            end else if (i_cmd.pop) begin
                r_sp <= w_sp_dec;
            end
            if (i_cmd.emit_done) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_k     <= '0;
            end else if (i_cmd.emit_rd) begin
                r_k <= r_k + AW'(1);
            end
        end
    end

    // Scan registers and result flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_range) begin
            r_lo <= r_stk_rd[AW-1:0];
            r_hi <= r_stk_rd[2*AW-1:AW];
        end
        if (i_cmd.take_pivot) begin
            r_pivot <= r_rd_a;
            r_place <= r_lo;
            r_j     <= r_lo;
        end else begin
            if (i_cmd.inc_place) begin
                r_place <= r_place + AW'(1);
            end
            if (i_cmd.inc_j) begin
                r_j <= r_j + AW'(1);
            end
        end
        if (i_cmd.emit_rd) begin
            r_last    <= o_stat.k_last;
            r_dropped <= r_ovf;
        end
    end

    always_comb begin
        o_stat.le         = ($signed(r_rd_a) <= $signed(r_pivot));
        o_stat.place_eq_j = (r_place == r_j);
        o_stat.j_eq_hi    = (r_j == r_hi);
        o_stat.sp_zero    = (r_sp == '0);
        o_stat.n_lt2      = (r_count < CW'(2));
        o_stat.k_last     = ((CW'(r_k) + CW'(1)) == r_count);
        o_stat.push_l_ok  = (w_left_len >= (AW + 1)'(2));
        o_stat.push_r_ok  = (w_right_len >= (AW + 1)'(2));
    end

    assign o_sorted_value = r_rd_a;
    assign o_last_out     = r_last;
    assign o_dropped      = r_dropped;
    assign o_strobe       = r_strobe;

endmodule
`default_nettype wire

### rtl/quicksort_lomuto_sorter_core.sv
`default_nettype none
// ============================================================================
// quicksort_lomuto_sorter_core: in-place quicksort of a set of signed words
// Collects up to DEPTH signed 32-bit items, sorts them with a Lomuto
// partition quicksort driven by an explicit range stack, and streams out the
// sorted set.
// ============================================================================
// Items load one per cycle while busy is low. After the item marked last, each
// partition pops a range, reads its high element as the pivot, compares every
// scanned element with it, swapping each one that is not greater into place, then
// places the pivot and pushes the subranges of two or more elements. Results follow
// one per cycle from a registered read and cannot be stalled; the next set's first item
// is taken while the final result is shown. Synchronous active-low reset empties
// the set and the range stack.
// ============================================================================
module quicksort_lomuto_sorter_core #(
    parameter int DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Item input. An item is taken at a clock edge with start high and busy
    // low.
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_value,
    input  wire logic        i_last_in,
    // Results. Each one is valid for exactly the single cycle that o_strobe
    // marks.
    output logic             o_strobe,
    output logic [31:0]      o_sorted_value,
    output logic             o_last_out,
    output logic             o_dropped
);
    import qsl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller sequences the load, sort and emission phases. It is busy
    // from the item marked last until the final sorted element has been read
    // out, and accepts the next set's first item right after that.
    qsl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_last_in (i_last_in),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    // The datapath keeps the elements and the range stack in memories. An item
    // that arrives with the store full is discarded, and the set's dropped
    // flag then marks every result of that set.
    qsl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_value        (i_value),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_dropped      (o_dropped),
        .o_strobe       (o_strobe)
    );

endmodule
`default_nettype wire
